[rtl/core/bgcp_pkg.sv]
// shared types and constants for the bigram count and probability block
package bgcp_pkg;

  localparam logic [1:0] REQ_TRAIN = 2'd0;
  localparam logic [1:0] REQ_EOS   = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;
  localparam logic [1:0] REQ_NONE  = 2'd3;

  localparam logic [63:0] MARK_START = 64'h3E733C;
  localparam logic [63:0] MARK_END   = 64'h3E732F3C;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] word;
    logic [63:0] query_prev;
  } bgcp_in_t;

  typedef struct packed {
    logic [6:0]  word_index;
    logic [16:0] prob_q16;
    logic        table_full;
  } bgcp_out_t;

endpackage

[rtl/core/bigram_count_and_probability.sv]
// top level of the bigram count and probability block
// One transaction at a time: busy is high from the accepting edge up to and including
// the cycle of out_valid, and the next transaction is accepted once busy is low again.
// Each item runs the word table search through the single ram port, once for each of
// the two words, and then writes any new words. Training and end-of-sentence items go
// on to update the word and pair counts, and a query that divides goes on to the
// one-bit-a-cycle divider, COUNT_BITS + 16 steps. A query ends without dividing when
// the previous word has no count or the answer is certain. A full table ends the item
// after the search, and an unused request type goes straight to the result. After
// reset the pair count ram is cleared one entry a cycle, with busy held high. Results
// are shown for one cycle on out_valid and cannot be held off.
`default_nettype none
module bigram_count_and_probability
  import bgcp_pkg::*;
#(
  parameter int MAX_WORDS  = 128,
  parameter int WORD_BYTES = 8,
  parameter int COUNT_BITS = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire bgcp_in_t  in_data,
  output logic           out_valid,
  output bgcp_out_t      out_data
);
  localparam int IW = $clog2(MAX_WORDS);
  localparam int UW = $clog2(MAX_WORDS + 1);
  localparam int PW = 2 * IW;
  localparam logic [63:0] WMASK = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - 8 * WORD_BYTES);
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  typedef enum logic [15:0] {
    S_CLEAR  = 16'h0001,
    S_IDLE   = 16'h0002,
    S_SETUP  = 16'h0004,
    S_SRD    = 16'h0008,
    S_SCMP   = 16'h0010,
    S_SNEXT  = 16'h0020,
    S_CHECK  = 16'h0040,
    S_WRA    = 16'h0080,
    S_WRB    = 16'h0100,
    S_CRD    = 16'h0200,
    S_CWAIT  = 16'h0400,
    S_CUPD   = 16'h0800,
    S_PRD    = 16'h1000,
    S_PWAIT  = 16'h2000,
    S_DIV    = 16'h4000,
    S_DONE   = 16'h8000
  } st_t;

  st_t st_r, st_nxt;
  logic [1:0]  req_r, req_nxt;
  logic [63:0] a_r, a_nxt, b_r, b_nxt;
  logic [UW-1:0] used_r, used_nxt, idx_r, idx_nxt;
  logic [IW-1:0] sa_r, sa_nxt, sb_r, sb_nxt, prev_r, prev_nxt;
  logic fa_r, fa_nxt, fb_r, fb_nxt, phase_r, phase_nxt, insent_r, insent_nxt;
  logic cstep_r, cstep_nxt, full_r, full_nxt, bend_r, bend_nxt;
  logic [PW:0] clr_r, clr_nxt;
  logic [MAX_WORDS-1:0] cval_r, cval_nxt;
  logic [COUNT_BITS-1:0] den_r, den_nxt;
  logic [16:0] prob_r, prob_nxt;

  logic          wst_we;
  logic [IW-1:0] wst_addr;
  logic [63:0]   wst_wd, wst_rd;
  logic          wc_we;
  logic [IW-1:0] wc_addr;
  logic [COUNT_BITS-1:0] wc_wd, wc_rd, wc_val;
  logic          pc_we;
  logic [PW-1:0] pc_addr;
  logic [COUNT_BITS-1:0] pc_wd, pc_rd;
  logic div_go, div_done;
  logic [16:0] div_q;
  logic [UW:0] need;
  logic [63:0] tgt;

  bgcp_ram #(.WIDTH(64), .DEPTH(MAX_WORDS)) u_wst (
    .clk(clk), .we(wst_we), .addr(wst_addr), .wdata(wst_wd), .rdata(wst_rd));
  bgcp_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_WORDS)) u_wc (
    .clk(clk), .we(wc_we), .addr(wc_addr), .wdata(wc_wd), .rdata(wc_rd));
  bgcp_ram #(.WIDTH(COUNT_BITS), .DEPTH(1 << PW)) u_pc (
    .clk(clk), .we(pc_we), .addr(pc_addr), .wdata(pc_wd), .rdata(pc_rd));
  bgcp_div #(.COUNT_BITS(COUNT_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .go(div_go), .num(pc_rd), .den(den_r),
    .done(div_done), .quo(div_q));

  assign wc_val = cval_r[wc_addr] ? wc_rd : '0;

  always_comb begin
    st_nxt = st_r; req_nxt = req_r; a_nxt = a_r; b_nxt = b_r;
    used_nxt = used_r; idx_nxt = idx_r; sa_nxt = sa_r; sb_nxt = sb_r;
    prev_nxt = prev_r; fa_nxt = fa_r; fb_nxt = fb_r; phase_nxt = phase_r;
    insent_nxt = insent_r; cstep_nxt = cstep_r; full_nxt = full_r;
    bend_nxt = bend_r; clr_nxt = clr_r; cval_nxt = cval_r;
    den_nxt = den_r; prob_nxt = prob_r;
    wst_we = 1'b0; wst_addr = idx_r[IW-1:0]; wst_wd = a_r;
    wc_we = 1'b0; wc_addr = cstep_r ? sb_r : sa_r; wc_wd = '0;
    pc_we = 1'b0; pc_addr = {sa_r, sb_r}; pc_wd = '0;
    div_go = 1'b0;
    need = '0;
    tgt = (in_data.req_type == REQ_TRAIN) ? (in_data.word & WMASK) : (MARK_END & WMASK);
    unique case (st_r)
      S_CLEAR: begin
        pc_we = 1'b1;
        pc_addr = clr_r[PW-1:0];
        clr_nxt = clr_r + 1'b1;
        if (clr_r[PW]) begin
          pc_we = 1'b0;
          st_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          req_nxt = in_data.req_type;
          full_nxt = 1'b0;
          prob_nxt = '0;
          if (in_data.req_type == REQ_QUERY) begin
            a_nxt = in_data.query_prev & WMASK;
            b_nxt = in_data.word & WMASK;
          end else if (insent_r) begin
            a_nxt = tgt;
            b_nxt = tgt;
          end else begin
            a_nxt = MARK_START & WMASK;
            b_nxt = tgt;
          end
          st_nxt = (in_data.req_type == REQ_NONE) ? S_DONE : S_SETUP;
        end
      end
      S_SETUP: begin
        idx_nxt = '0; fa_nxt = 1'b0; fb_nxt = 1'b0; phase_nxt = 1'b0;
        st_nxt = S_SRD;
      end
      S_SRD: begin
        if (idx_r >= used_r) begin
          if (phase_r) st_nxt = S_CHECK;
          else begin
            phase_nxt = 1'b1; idx_nxt = '0;
          end
        end else st_nxt = S_SCMP;
      end
      S_SCMP: begin
        if (!phase_r && !fa_r && wst_rd == a_r) begin
          fa_nxt = 1'b1; sa_nxt = idx_r[IW-1:0];
        end
        if (phase_r && !fb_r && wst_rd == b_r) begin
          fb_nxt = 1'b1; sb_nxt = idx_r[IW-1:0];
        end
        idx_nxt = idx_r + 1'b1;
        st_nxt = S_SRD;
      end
      S_SNEXT: st_nxt = S_SRD;
      S_CHECK: begin
        need = {1'b0, used_r} + (fa_r ? '0 : (UW+1)'(1))
             + ((fb_r || a_r == b_r) ? '0 : (UW+1)'(1));
        if (need > (UW+1)'(MAX_WORDS)) begin
          full_nxt = 1'b1; st_nxt = S_DONE;
        end else st_nxt = S_WRA;
      end
      S_WRA: begin
        if (!fa_r) begin
          wst_we = 1'b1; wst_addr = used_r[IW-1:0]; wst_wd = a_r;
          sa_nxt = used_r[IW-1:0];
          used_nxt = used_r + 1'b1;
          if (a_r == b_r) sb_nxt = used_r[IW-1:0];
        end else if (a_r == b_r) sb_nxt = sa_r;
        st_nxt = S_WRB;
      end
      S_WRB: begin
        if (!fb_r && a_r != b_r) begin
          wst_we = 1'b1; wst_addr = used_r[IW-1:0]; wst_wd = b_r;
          sb_nxt = used_r[IW-1:0];
          used_nxt = used_r + 1'b1;
        end
        bend_nxt = (b_r == (MARK_END & WMASK));
        if (req_r != REQ_QUERY && insent_r) sa_nxt = prev_r;
        cstep_nxt = (req_r != REQ_QUERY && insent_r);
        st_nxt = (req_r == REQ_QUERY) ? S_PRD : S_CRD;
      end
      S_CRD: st_nxt = S_CWAIT;
      S_CWAIT: st_nxt = S_CUPD;
      S_CUPD: begin
        wc_we = 1'b1;
        wc_wd = (wc_val < CMAX) ? wc_val + 1'b1 : wc_val;
        cval_nxt[wc_addr] = 1'b1;
        if (!cstep_r) begin
          cstep_nxt = 1'b1; st_nxt = S_CRD;
        end else begin
          pc_we = 1'b1;
          pc_wd = (pc_rd < CMAX) ? pc_rd + 1'b1 : pc_rd;
          if (req_r == REQ_TRAIN) begin
            prev_nxt = sb_r; insent_nxt = 1'b1;
          end else begin
            prev_nxt = '0; insent_nxt = 1'b0;
          end
          st_nxt = S_DONE;
        end
      end
      S_PRD: begin
        wc_addr = sa_r;
        st_nxt = S_PWAIT;
      end
      S_PWAIT: begin
        wc_addr = sa_r;
        den_nxt = wc_val;
        if (wc_val == '0) st_nxt = S_DONE;
        else if (bend_r && pc_rd != '0) begin
          prob_nxt = 17'h10000; st_nxt = S_DONE;
        end else begin
          div_go = 1'b1; st_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          prob_nxt = div_q; st_nxt = S_DONE;
        end
      end
      S_DONE: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLEAR;
      used_r <= '0;
      prev_r <= '0;
      insent_r <= 1'b0;
      clr_r <= '0;
      cval_r <= '0;
    end else begin
      st_r <= st_nxt;
      used_r <= used_nxt;
      prev_r <= prev_nxt;
      insent_r <= insent_nxt;
      clr_r <= clr_nxt;
      cval_r <= cval_nxt;
    end
    req_r <= req_nxt; a_r <= a_nxt; b_r <= b_nxt; idx_r <= idx_nxt;
    sa_r <= sa_nxt; sb_r <= sb_nxt; fa_r <= fa_nxt; fb_r <= fb_nxt;
    phase_r <= phase_nxt; cstep_r <= cstep_nxt; full_r <= full_nxt;
    bend_r <= bend_nxt; den_r <= den_nxt; prob_r <= prob_nxt;
  end

  assign busy = (st_r != S_IDLE);
  assign out_valid = (st_r == S_DONE);
  always_comb begin
    out_data.table_full = full_r;
    out_data.word_index = (full_r || req_r == REQ_NONE) ? 7'd0 : 7'(sb_r);
    out_data.prob_q16 = (full_r || req_r != REQ_QUERY) ? 17'd0 : prob_r;
  end
endmodule
`default_nettype wire

[rtl/core/bgcp_ram.sv]
// generic single port ram with registered read
`default_nettype none
module bgcp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

[rtl/core/bgcp_div.sv]
// serial restoring divider for the q16 ratio
`default_nettype none
module bgcp_div #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  go,
  input  wire logic [COUNT_BITS-1:0] num,
  input  wire logic [COUNT_BITS-1:0] den,
  output logic                       done,
  output logic [16:0]                quo
);
  localparam int NB = COUNT_BITS + 16;
  localparam int CB = $clog2(NB + 1);

  logic [NB-1:0]       q_r, q_nxt;
  logic [COUNT_BITS:0] rem_r, rem_nxt, trial;
  logic [CB-1:0]       cnt_r, cnt_nxt;
  logic                run_r, run_nxt, done_r, done_nxt;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    run_nxt = run_r;
    done_nxt = 1'b0;
    trial = {rem_r[COUNT_BITS-1:0], q_r[NB-1]};
    if (go) begin
      q_nxt = {num, 16'd0};
      rem_nxt = '0;
      cnt_nxt = CB'(NB);
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (trial >= {1'b0, den}) begin
        rem_nxt = trial - {1'b0, den};
        q_nxt = {q_r[NB-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[NB-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CB'(1)) begin
        run_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign quo = (q_r > NB'(65536)) ? 17'h10000 : q_r[16:0];
endmodule
`default_nettype wire

[bench/tb_top.sv]
// self-checking testbench for the bigram count and probability block
module tb_top;
  import bgcp_pkg::*;

  localparam int WORDS = 128;
  localparam int CMAX = 65535;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  bgcp_in_t in_data = '0;
  logic out_valid;
  bgcp_out_t out_data;
  int errors = 0;

  always #10 clk = ~clk;

  bigram_count_and_probability dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  // shadow model of the word table and counts
  logic [63:0] lex [WORDS];
  int lex_used;
  int unigram [WORDS];
  int bigram [WORDS][WORDS];
  int prev_slot;
  bit in_sentence;
  bgcp_out_t pending_results[$];

  function automatic int find_word(logic [63:0] w);
    for (int i = 0; i < lex_used; i++) if (lex[i] == w) return i;
    return -1;
  endfunction

  function automatic bit add_pair(logic [63:0] a, logic [63:0] b,
                                  output int sa, output int sb);
    int fa, fb, need;
    fa = find_word(a);
    fb = find_word(b);
    need = (fa < 0) + ((fb < 0 && a != b) ? 1 : 0);
    if (lex_used + need > WORDS) return 0;
    if (fa < 0) begin
      lex[lex_used] = a;
      fa = lex_used++;
    end
    if (fb < 0) begin
      if (a == b) fb = fa;
      else begin
        lex[lex_used] = b;
        fb = lex_used++;
      end
    end
    sa = fa;
    sb = fb;
    return 1;
  endfunction

  function automatic bgcp_out_t bigram_predict(bgcp_in_t t);
    bgcp_out_t r;
    int sa, sb, den, pc;
    logic [63:0] target;
    longint p;
    r = '0;
    if (t.req_type == REQ_TRAIN || t.req_type == REQ_EOS) begin
      target = (t.req_type == REQ_TRAIN) ? t.word : MARK_END;
      if (in_sentence) begin
        if (add_pair(target, target, sa, sb)) sa = prev_slot;
        else r.table_full = 1'b1;
      end else if (add_pair(MARK_START, target, sa, sb)) begin
        if (unigram[sa] < CMAX) unigram[sa]++;
      end else r.table_full = 1'b1;
      if (!r.table_full) begin
        if (unigram[sb] < CMAX) unigram[sb]++;
        if (bigram[sa][sb] < CMAX) bigram[sa][sb]++;
        r.word_index = sb[6:0];
        prev_slot = (t.req_type == REQ_TRAIN) ? sb : 0;
        in_sentence = (t.req_type == REQ_TRAIN);
      end
    end else if (t.req_type == REQ_QUERY) begin
      if (add_pair(t.query_prev, t.word, sa, sb)) begin
        den = unigram[sa];
        pc = bigram[sa][sb];
        r.word_index = sb[6:0];
        if (den == 0) p = 0;
        else if (lex[sb] == MARK_END && pc > 0) p = 65536;
        else begin
          p = (longint'(pc) << 16) / den;
          if (p > 65536) p = 65536;
        end
        r.prob_q16 = p[16:0];
      end else r.table_full = 1'b1;
    end
    return r;
  endfunction

  // result checking
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data);
        errors++;
      end else begin
        bgcp_out_t e;
        e = pending_results.pop_front();
        if (e.word_index != out_data.word_index) begin
          $display("%0t: word_index exp %0d got %0d", $time, e.word_index,
                   out_data.word_index);
          errors++;
        end
        if (e.prob_q16 != out_data.prob_q16) begin
          $display("%0t: prob_q16 exp %0d got %0d", $time, e.prob_q16,
                   out_data.prob_q16);
          errors++;
        end
        if (e.table_full != out_data.table_full) begin
          $display("%0t: table_full exp %0d got %0d", $time, e.table_full,
                   out_data.table_full);
          errors++;
        end
      end
    end
  end

  // directed rows: typed expectation used where given
  typedef struct {
    bgcp_in_t  txn;
    bit        typed;
    bgcp_out_t res;
  } row_t;

  // returns at the accepting edge with start still high
  task automatic send(bgcp_in_t t, bit typed, bgcp_out_t res);
    bgcp_out_t p;
    start <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (busy) @(posedge clk);
    p = bigram_predict(t);
    pending_results.push_back(typed ? res : p);
  endtask

  function automatic logic [63:0] rand_word(int pool);
    logic [63:0] w;
    case ($urandom_range(0, 9))
      0: w = {$urandom, $urandom};
      1: w = 64'hFFFF_FFFF_FFFF_FFFF;
      default: w = 64'h6100 + $urandom_range(0, pool - 1);
    endcase
    return w;
  endfunction

  task automatic run_random(int n, int pool);
    bgcp_in_t t;
    int burst;
    int gap;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 20);
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst--;
      t.word = rand_word(pool);
      t.query_prev = rand_word(pool);
      case ($urandom_range(0, 15))
        0, 1: t.req_type = REQ_EOS;
        2, 3, 4: t.req_type = REQ_QUERY;
        5: t.req_type = REQ_NONE;
        default: t.req_type = REQ_TRAIN;
      endcase
      send(t, 1'b0, '0);
    end
  endtask

  initial begin
    row_t rows[$];
    row_t rw;
    for (int i = 0; i < WORDS; i++) begin
      unigram[i] = 0;
      for (int j = 0; j < WORDS; j++) bigram[i][j] = 0;
    end
    lex_used = 0;
    prev_slot = 0;
    in_sentence = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // query before any training: both words new, probability zero
    rw.txn = '{REQ_QUERY, 64'h61, 64'h62}; rw.typed = 1; rw.res = '{7'd1, 17'd0, 1'b0};
    rows.push_back(rw);
    rw.typed = 0; rw.res = '0;
    rw.txn = '{REQ_EOS, 64'h0, 64'h0};                       rows.push_back(rw);
    rw.txn = '{REQ_TRAIN, 64'h61, 64'hFFFF_FFFF_FFFF_FFFF}; rows.push_back(rw);
    rw.txn = '{REQ_TRAIN, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0};   rows.push_back(rw);
    rw.txn = '{REQ_TRAIN, 64'h0, 64'h0};                     rows.push_back(rw);
    rw.txn = '{REQ_TRAIN, 64'h0, 64'h0};                     rows.push_back(rw);
    rw.txn = '{REQ_EOS, 64'h61, 64'h62};                     rows.push_back(rw);
    rw.txn = '{REQ_QUERY, MARK_END, 64'h0};                  rows.push_back(rw);
    rw.txn = '{REQ_QUERY, 64'h61, MARK_START};               rows.push_back(rw);
    rw.txn = '{REQ_QUERY, MARK_END, MARK_START};             rows.push_back(rw);
    rw.txn = '{REQ_QUERY, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF};   rows.push_back(rw);
    rw.txn = '{REQ_TRAIN, MARK_START, 64'h0};                rows.push_back(rw);
    rw.txn = '{REQ_QUERY, 64'h63, 64'h63};                   rows.push_back(rw);
    rw.txn = '{REQ_NONE, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF}; rw.typed = 1;
    rows.push_back(rw);
    foreach (rows[i]) send(rows[i].txn, rows[i].typed, rows[i].res);

    // small vocabulary for deep counts, then fill the table
    run_random(1000, 24);
    run_random(400, 400);

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0)
      $display("bigram_count_and_probability verification clean");
    else
      $display("bigram_count_and_probability verification failed");
    $finish;
  end

  initial begin
    #100_000_000;
    $display("bigram_count_and_probability verification failed");
    $finish;
  end
endmodule
